@@ rtl/prf_pkg.sv @@
// shared types and constants for the pollard rho divisor finder
package prf_pkg;

	localparam int unsigned PRF_WIDTH = 32;

	typedef struct packed {
		logic [31:0] number;
		logic [31:0] seed_x;
		logic [31:0] seed_c;
	} prf_in_t;

	typedef struct packed {
		logic [31:0] divisor;
		logic        status;
	} prf_out_t;

	typedef struct packed {
		logic start;
		logic busy;
	} prf_div_ctl_t;

endpackage

@@ rtl/prf_divider.sv @@
// shared restoring divider: one quotient bit per cycle, gives the remainder
module prf_divider import prf_pkg::*; #(
	parameter int unsigned W  = PRF_WIDTH,
	parameter int unsigned DW = 2*W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [W-1:0]  divisor_in,
	output prf_div_ctl_t  ctl,
	output logic [W-1:0]  remainder
);
	localparam int unsigned CW = $clog2(DW+1);

	logic [DW-1:0]  quo_q;
	logic [W:0]     rem_q;
	logic [W-1:0]   dvs_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [W:0]     shifted;
	logic [W:0]     diff;

	assign shifted = {rem_q[W-1:0], quo_q[DW-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor_in;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], 1'b0};
			rem_q <= diff[W] ? shifted : diff;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign remainder = rem_q[W-1:0];
endmodule

@@ rtl/pollard_rho_factor_finder_unit.sv @@
// top level of the pollard rho divisor finder
// one number per start beat; busy stays high until the single result beat.
// every mod of the seed reductions, the square reductions and the euclid steps
// goes through one shared bit-serial divider with dividend width DW = max(2*WIDTH, 32);
// the add after each square is reduced by one conditional subtract. setup
// reduces the start value and the addend, then each rho round runs three
// square reductions plus the euclid divisions, so the total is data
// dependent; 1, even and zero n give done without using the divider.
// done is high for one cycle and cannot be held off; result holds until the next start.
module pollard_rho_factor_finder_unit import prf_pkg::*; #(
	parameter int unsigned WIDTH = PRF_WIDTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  prf_in_t  operand,
	output logic     busy,
	output logic     done,
	output prf_out_t result
);
	// dividend width: holds a square and a full 32-bit seed
	localparam int unsigned DW = (2*WIDTH > 32) ? 2*WIDTH : 32;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0, ST_SX = 4'd1, ST_SC = 4'd2,
		ST_SQ = 4'd3, ST_ADD = 4'd4, ST_GCD = 4'd5, ST_OUT = 4'd6,
		ST_WAIT = 4'd7;
	// which walk step is running
	localparam logic [1:0] WK_X = 2'd0, WK_Y1 = 2'd1, WK_Y2 = 2'd2;

	logic [3:0]       st_q, ret_q;
	logic [1:0]       wk_q;
	logic [WIDTH-1:0] n_q, x_q, y_q, c_q, gb_q, v_q;
	logic [31:0]      sc_q;
	logic             done_q;
	prf_out_t         res_q;

	logic             dstart;
	logic [DW-1:0]    dvd;
	logic [WIDTH-1:0] dvs, rem;
	prf_div_ctl_t     dctl;
	logic [WIDTH-1:0] nin;
	logic [WIDTH:0]   sum;

	// one squarer shared by all walk steps
	logic [WIDTH-1:0]   mul_op;
	logic [2*WIDTH-1:0] mul_sq;

	assign nin = operand.number[WIDTH-1:0];
	assign sum = {1'b0, rem} + {1'b0, c_q};

	always_comb begin
		mul_op = x_q;
		if (st_q == ST_ADD) mul_op = (wk_q == WK_X) ? y_q : v_q;
	end
	assign mul_sq = {{WIDTH{1'b0}}, mul_op} * {{WIDTH{1'b0}}, mul_op};

	prf_divider #(.W(WIDTH), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(dvd),
		.divisor_in(dvs), .ctl(dctl), .remainder(rem)
	);

	// divider launch happens in the state-transition block through these regs
	logic             go_q;
	logic [DW-1:0]    dvd_q;
	logic [WIDTH-1:0] dvs_q;
	assign dstart = go_q;
	assign dvd    = dvd_q;
	assign dvs    = dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ret_q  <= ST_IDLE;
			wk_q   <= WK_X;
			go_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (start) begin
					if (nin == WIDTH'(1) || !nin[0]) begin
						st_q <= ST_OUT;
					end else begin
						// start value: seed_x mod (n-2)
						go_q <= 1'b1;
						st_q <= ST_WAIT;
						ret_q <= ST_SX;
					end
				end
				ST_WAIT: if (!go_q && !dctl.busy) st_q <= ret_q;
				ST_SX: begin
					go_q <= 1'b1; st_q <= ST_WAIT; ret_q <= ST_SC;
				end
				ST_SC: begin
					wk_q <= WK_X;
					go_q <= 1'b1; st_q <= ST_WAIT; ret_q <= ST_SQ;
				end
				ST_SQ: begin
					st_q <= ST_ADD;
				end
				ST_ADD: begin
					// (sq + c) mod n: sum < 2n, one conditional subtract
					case (wk_q)
						WK_X: begin
							wk_q <= WK_Y1; go_q <= 1'b1;
							st_q <= ST_WAIT; ret_q <= ST_SQ;
						end
						WK_Y1: begin
							wk_q <= WK_Y2; go_q <= 1'b1;
							st_q <= ST_WAIT; ret_q <= ST_SQ;
						end
						default: begin
							wk_q <= WK_X; go_q <= 1'b1;
							st_q <= ST_WAIT; ret_q <= ST_GCD;
						end
					endcase
				end
				ST_GCD: begin
					if (rem != '0) begin
						go_q <= 1'b1; st_q <= ST_WAIT; ret_q <= ST_GCD;
					end else if (gb_q == WIDTH'(1)) begin
						go_q <= 1'b1; st_q <= ST_WAIT; ret_q <= ST_SQ;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					done_q <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (start) begin
				n_q   <= nin;
				sc_q  <= operand.seed_c;
				dvd_q <= DW'(operand.seed_x);
				dvs_q <= nin - WIDTH'(2);
				if (nin == WIDTH'(1)) res_q <= '{divisor: 32'd1, status: 1'b0};
				else res_q <= '{divisor: 32'd2, status: 1'b0};
			end
			ST_SX: begin
				x_q   <= rem + WIDTH'(2);
				y_q   <= rem + WIDTH'(2);
				dvd_q <= DW'(sc_q);
				dvs_q <= n_q - WIDTH'(1);
			end
			ST_SC: begin
				c_q   <= rem + WIDTH'(1);
				dvd_q <= DW'(mul_sq);
				dvs_q <= n_q;
			end
			ST_SQ: begin
				// square result ready on rem (square of the value loaded earlier)
				v_q <= (sum >= {1'b0, n_q}) ? WIDTH'(sum - {1'b0, n_q})
					: sum[WIDTH-1:0];
			end
			ST_ADD: begin
				case (wk_q)
					WK_X: begin
						x_q <= v_q; dvd_q <= DW'(mul_sq);
					end
					WK_Y1: begin
						y_q <= v_q; dvd_q <= DW'(mul_sq);
					end
					default: begin
						y_q   <= v_q;
						gb_q  <= n_q;
						dvd_q <= DW'((x_q > v_q) ? x_q - v_q : v_q - x_q);
					end
				endcase
				dvs_q <= n_q;
			end
			ST_GCD: begin
				if (rem != '0) begin
					gb_q  <= rem;
					dvd_q <= DW'(gb_q);
					dvs_q <= rem;
				end else if (gb_q == WIDTH'(1)) begin
					dvd_q <= DW'(mul_sq);
					dvs_q <= n_q;
				end else if (gb_q == n_q) begin
					res_q <= '{divisor: 32'd0, status: 1'b1};
				end else begin
					res_q <= '{divisor: 32'(gb_q), status: 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign busy   = (st_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_div_idle_launch: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> !dctl.busy) else $error("divider relaunched while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
`endif
endmodule
